@@ hdl/pssb_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pssb_pkg
// Shared types, widths, register indexes and rounding helper for the
// phasing SSB modulator.
// ============================================================================
package pssb_pkg;

  localparam int DELAY_DEPTH = 150;
  localparam int SAMPLE_BITS = 16;
  localparam int PTR_W       = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;

  localparam int OSC_W      = 18;
  localparam int OSC_FRAC   = 16;
  localparam int GAIN_W     = OSC_W + 1;
  localparam int MUL_W      = (SAMPLE_BITS > GAIN_W) ? SAMPLE_BITS : GAIN_W;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int MIX_W      = SAMPLE_BITS + OSC_W + 1;
  localparam int MIX_FRAC   = SAMPLE_BITS - 1 + OSC_FRAC;
  localparam int DAC_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = OSC_W;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [OSC_W-1:0]       osc_t;
  typedef logic signed [GAIN_W-1:0]      gain_t;
  typedef logic signed [MUL_W-1:0]       mul_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [MIX_W-1:0]       mix_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_COS = 2'd0,
    CFG_ROT_SIN = 2'd1,
    CFG_LSB     = 2'd2
  } cfg_reg_e;

  localparam osc_t  OSC_ONE   = osc_t'(1 << OSC_FRAC);
  localparam osc_t  OSC_MAX   = osc_t'((1 << (OSC_W - 1)) - 1);
  localparam osc_t  OSC_MIN   = osc_t'(-(1 << (OSC_W - 1)));
  localparam prod_t PROD_HI   = prod_t'((1 << (OSC_W - 1)) - 1);
  localparam prod_t PROD_LO   = prod_t'(-(1 << (OSC_W - 1)));
  localparam prod_t RND_HALF  = prod_t'(1 << (OSC_FRAC - 1));
  localparam prod_t RND_ONE   = prod_t'(1 << OSC_FRAC);
  localparam prod_t GAIN_BASE = prod_t'(3 << (OSC_FRAC - 1));

  // Q.32 product to Q16, round half up, saturate to oscillator width
  function automatic osc_t round_sat(input prod_t x);
    prod_t r;
    r = (x + RND_HALF) >>> OSC_FRAC;
    if (r > PROD_HI) begin
      return OSC_MAX;
    end else if (r < PROD_LO) begin
      return OSC_MIN;
    end
    return osc_t'(r);
  endfunction

endpackage

@@ hdl/pssb_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pssb_if
// Valid/ready channel interfaces: sample input, DAC output, register writes.
// ============================================================================
interface pssb_in_if;
  logic                    valid;
  logic                    ready;
  pssb_pkg::sample_t       audio_sample;
  pssb_pkg::sample_t       quadrature_sample;
  logic                    last_in_block;

  modport source (output valid, audio_sample, quadrature_sample, last_in_block,
                  input ready);
  modport sink   (input valid, audio_sample, quadrature_sample, last_in_block,
                  output ready);
endinterface

interface pssb_out_if;
  logic                          valid;
  logic                          ready;
  logic [pssb_pkg::DAC_W-1:0]    dac_code;
  logic                          block_end;

  modport source (output valid, dac_code, block_end, input ready);
  modport sink   (input valid, dac_code, block_end, output ready);
endinterface

interface pssb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pssb_pkg::CFG_IDX_W-1:0]   index;
  logic [pssb_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/phasing_ssb_modulator_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// phasing_ssb_modulator_top
// Phasing-method SSB modulator producing 12-bit DAC codes.
// ============================================================================
// Usage:
//   smp_i : one item = audio sample, its Hilbert quadrature sample and a
//           block-end flag. Ready only while the sequencer is idle.
//   dac_o : one item per input = clamped DAC code plus the block-end copy.
//   cfg_i : register writes (rotation cos, rotation sin, sideband select),
//           always ready; write only while no item is in flight.
// Timing: an item steps through MIX_A/B, RE_A/B, IM_A/B, MAG_A/B, GAIN,
//   SCL_RE, SCL_IM, UPD_IM and DONE; the next item can be accepted
//   once the result is registered, not while one is in work. The single
//   shared 19x19 multiplier, used ten times per item, sets this pace.
// Reset: oscillator returns to (1, 0), delay line reads as zero, rotation
//   registers to cos 0 / sin 1, upper sideband.
// Stall: a result waits in the output register; a new item is accepted
//   and worked on meanwhile, and the sequencer holds in its last step
//   until the output register is free.
// ============================================================================
module phasing_ssb_modulator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  pssb_in_if.sink     smp_i,
  pssb_out_if.source  dac_o,
  pssb_cfg_if.sink    cfg_i
);

  pssb_pkg::sample_t dly_sample;

  pssb_delay u_delay (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (smp_i.valid && smp_i.ready),
    .wr_data_i (smp_i.audio_sample),
    .rd_data_o (dly_sample)
  );

  pssb_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .delayed_i (dly_sample),
    .smp_i     (smp_i),
    .dac_o     (dac_o),
    .cfg_i     (cfg_i)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_i.valid && smp_i.ready |=> !smp_i.ready)
    else $error("input ready right after accept");

  a_result_from_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(dac_o.valid) |-> $past(!smp_i.ready))
    else $error("result appeared without an item in work");

  a_cfg_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid |-> cfg_i.ready)
    else $error("register write stalled");
`endif

endmodule

@@ hdl/pssb_mul.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pssb_mul
// Shared signed multiplier with registered product.
// ============================================================================
module pssb_mul (
  input  logic            clk_i,
  input  pssb_pkg::mul_t  a_i,
  input  pssb_pkg::mul_t  b_i,
  output pssb_pkg::prod_t p_o
);

  pssb_pkg::prod_t p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

@@ hdl/pssb_delay.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pssb_delay
// Circular delay line: read-before-write at the pointer on each item,
// registered read. Entries never written read as zero via valid bits.
// ============================================================================
module pssb_delay (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  pssb_pkg::sample_t wr_data_i,
  output pssb_pkg::sample_t rd_data_o
);

  pssb_pkg::sample_t                    mem_q [pssb_pkg::DELAY_DEPTH];
  logic [pssb_pkg::DELAY_DEPTH-1:0]     vld_q;
  logic [pssb_pkg::PTR_W-1:0]           ptr_q, ptr_d;
  pssb_pkg::sample_t                    rd_q;
  logic                                 rd_vld_q;

  always_comb begin
    ptr_d = ptr_q;
    if (wr_en_i) begin
      if (ptr_q == pssb_pkg::PTR_W'(pssb_pkg::DELAY_DEPTH - 1)) begin
        ptr_d = '0;
      end else begin
        ptr_d = ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      ptr_q <= ptr_d;
      if (wr_en_i) begin
        rd_vld_q     <= vld_q[ptr_q];
        vld_q[ptr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rd_q         <= mem_q[ptr_q];
      mem_q[ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

@@ hdl/pssb_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pssb_core
// Sequencer around the shared multiplier: mix, oscillator rotation,
// Newton renormalization, DAC scaling and output register.
// ============================================================================
module pssb_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pssb_pkg::sample_t delayed_i,
  pssb_in_if.sink           smp_i,
  pssb_out_if.source        dac_o,
  pssb_cfg_if.sink          cfg_i
);

  localparam int T_W = pssb_pkg::MIX_W + 12;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_MIX_A  = 14'b00000000000010,
    S_MIX_B  = 14'b00000000000100,
    S_RE_A   = 14'b00000000001000,
    S_RE_B   = 14'b00000000010000,
    S_IM_A   = 14'b00000000100000,
    S_IM_B   = 14'b00000001000000,
    S_MAG_A  = 14'b00000010000000,
    S_MAG_B  = 14'b00000100000000,
    S_GAIN   = 14'b00001000000000,
    S_SCL_RE = 14'b00010000000000,
    S_SCL_IM = 14'b00100000000000,
    S_UPD_IM = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_e;

  state_e            state_q, state_d;
  pssb_pkg::prod_t   acc_q, acc_d;
  pssb_pkg::mix_t    mix_q, mix_d;
  pssb_pkg::osc_t    nre_q, nre_d, nim_q, nim_d;
  pssb_pkg::gain_t   g_q, g_d;
  pssb_pkg::osc_t    ore_q, ore_d, oim_q, oim_d;
  pssb_pkg::osc_t    rot_cos_q, rot_cos_d, rot_sin_q, rot_sin_d;
  logic              lsb_q, lsb_d;
  pssb_pkg::sample_t quad_q;
  logic              last_q;
  logic              out_vld_q, out_vld_d;
  logic [pssb_pkg::DAC_W-1:0] out_code_q, code;
  logic              out_end_q;

  pssb_pkg::mul_t    op_a, op_b;
  pssb_pkg::prod_t   prod;
  pssb_pkg::prod_t   mag_half;
  logic signed [T_W-1:0] mix_ext, t_val, t_shr;
  logic              accept, publish;

  pssb_mul u_mul (
    .clk_i (clk_i),
    .a_i   (op_a),
    .b_i   (op_b),
    .p_o   (prod)
  );

  assign smp_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign accept      = smp_i.valid && smp_i.ready;
  assign publish     = (state_q == S_DONE) && (!out_vld_q || dac_o.ready);

  // operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      S_MIX_A:  begin op_a = pssb_pkg::mul_t'(delayed_i); op_b = pssb_pkg::mul_t'(ore_q); end
      S_MIX_B:  begin op_a = pssb_pkg::mul_t'(quad_q);    op_b = pssb_pkg::mul_t'(oim_q); end
      S_RE_A:   begin op_a = pssb_pkg::mul_t'(ore_q);     op_b = pssb_pkg::mul_t'(rot_cos_q); end
      S_RE_B:   begin op_a = pssb_pkg::mul_t'(oim_q);     op_b = pssb_pkg::mul_t'(rot_sin_q); end
      S_IM_A:   begin op_a = pssb_pkg::mul_t'(ore_q);     op_b = pssb_pkg::mul_t'(rot_sin_q); end
      S_IM_B:   begin op_a = pssb_pkg::mul_t'(oim_q);     op_b = pssb_pkg::mul_t'(rot_cos_q); end
      S_MAG_A:  begin op_a = pssb_pkg::mul_t'(nre_q);     op_b = pssb_pkg::mul_t'(nre_q); end
      S_MAG_B:  begin op_a = pssb_pkg::mul_t'(nim_q);     op_b = pssb_pkg::mul_t'(nim_q); end
      S_SCL_RE: begin op_a = pssb_pkg::mul_t'(nre_q);     op_b = pssb_pkg::mul_t'(g_q); end
      S_SCL_IM: begin op_a = pssb_pkg::mul_t'(nim_q);     op_b = pssb_pkg::mul_t'(g_q); end
      default:  begin op_a = '0; op_b = '0; end
    endcase
  end

  // DAC: floor(mix*1800 + 2048), clamped; 1800 = 2048 - 256 + 8
  always_comb begin
    mix_ext = T_W'(mix_q);
    t_val   = (mix_ext <<< 11) - (mix_ext <<< 8) + (mix_ext <<< 3)
              + (T_W'(2048) <<< pssb_pkg::MIX_FRAC);
    t_shr   = t_val >>> pssb_pkg::MIX_FRAC;
    if (t_val < 0) begin
      code = '0;
    end else if (t_shr > T_W'(4095)) begin
      code = '1;
    end else begin
      code = t_shr[pssb_pkg::DAC_W-1:0];
    end
  end

  assign mag_half = (acc_q + prod + pssb_pkg::RND_ONE) >>> (pssb_pkg::OSC_FRAC + 1);

  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    mix_d     = mix_q;
    nre_d     = nre_q;
    nim_d     = nim_q;
    g_d       = g_q;
    ore_d     = ore_q;
    oim_d     = oim_q;
    rot_cos_d = rot_cos_q;
    rot_sin_d = rot_sin_q;
    lsb_d     = lsb_q;
    out_vld_d = out_vld_q && !dac_o.ready;

    if (cfg_i.valid) begin
      case (pssb_pkg::cfg_reg_e'(cfg_i.index))
        pssb_pkg::CFG_ROT_COS: rot_cos_d = pssb_pkg::osc_t'(cfg_i.data);
        pssb_pkg::CFG_ROT_SIN: rot_sin_d = pssb_pkg::osc_t'(cfg_i.data);
        pssb_pkg::CFG_LSB:     lsb_d     = cfg_i.data[0];
        default:               lsb_d     = lsb_q;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_MIX_A;
        end
      end
      S_MIX_A: state_d = S_MIX_B;
      S_MIX_B: begin
        acc_d   = prod;
        state_d = S_RE_A;
      end
      S_RE_A: begin
        mix_d   = lsb_q ? pssb_pkg::MIX_W'(acc_q + prod) : pssb_pkg::MIX_W'(acc_q - prod);
        state_d = S_RE_B;
      end
      S_RE_B: begin
        acc_d   = prod;
        state_d = S_IM_A;
      end
      S_IM_A: begin
        nre_d   = pssb_pkg::round_sat(acc_q - prod);
        state_d = S_IM_B;
      end
      S_IM_B: begin
        acc_d   = prod;
        state_d = S_MAG_A;
      end
      S_MAG_A: begin
        nim_d   = pssb_pkg::round_sat(acc_q + prod);
        state_d = S_MAG_B;
      end
      S_MAG_B: begin
        acc_d   = prod;
        state_d = S_GAIN;
      end
      S_GAIN: begin
        g_d     = pssb_pkg::gain_t'(pssb_pkg::GAIN_BASE - mag_half);
        state_d = S_SCL_RE;
      end
      S_SCL_RE: state_d = S_SCL_IM;
      S_SCL_IM: begin
        ore_d   = pssb_pkg::round_sat(prod);
        state_d = S_UPD_IM;
      end
      S_UPD_IM: begin
        oim_d   = pssb_pkg::round_sat(prod);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (publish) begin
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ore_q     <= pssb_pkg::OSC_ONE;
      oim_q     <= '0;
      rot_cos_q <= '0;
      rot_sin_q <= pssb_pkg::OSC_ONE;
      lsb_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ore_q     <= ore_d;
      oim_q     <= oim_d;
      rot_cos_q <= rot_cos_d;
      rot_sin_q <= rot_sin_d;
      lsb_q     <= lsb_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mix_q <= mix_d;
    nre_q <= nre_d;
    nim_q <= nim_d;
    g_q   <= g_d;
    if (accept) begin
      quad_q <= smp_i.quadrature_sample;
      last_q <= smp_i.last_in_block;
    end
    if (publish) begin
      out_code_q <= code;
      out_end_q  <= last_q;
    end
  end

  assign dac_o.valid     = out_vld_q;
  assign dac_o.dac_code  = out_code_q;
  assign dac_o.block_end = out_end_q;

endmodule

@@ tb/pssb_dac_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pssb_dac_checker
// Watches the sample, DAC and register channels of the SSB modulator. It
// keeps its own copy of the delay line, oscillator and registers, predicts
// the DAC item for every accepted sample and compares the DAC items in order.
// ============================================================================
module pssb_dac_checker (
  input  logic clk_i,
  input  logic rst_ni,
  pssb_in_if   smp,
  pssb_out_if  dac,
  pssb_cfg_if  cfg,
  output int   pending_o,
  output int   errors_o
);

  localparam longint OSC_UNITY = 65536;
  localparam longint OSC_HI    = 131071;
  localparam longint OSC_LO    = -131072;
  localparam longint HALF_LSB  = 32768;
  localparam longint GAIN_Q16  = 98304;
  localparam longint DAC_SCALE = 1800;
  localparam longint DAC_MID   = 2048;
  localparam longint DAC_TOP   = 4095;

  typedef struct packed {
    logic [pssb_pkg::DAC_W-1:0] code;
    logic                       block_end;
  } dac_item_t;

  pssb_pkg::sample_t delay_line [pssb_pkg::DELAY_DEPTH];
  int                tap;
  longint            osc_re, osc_im, rot_cos, rot_sin;
  logic              lsb_sel;
  dac_item_t         dac_expect_q [$];
  int                fails;

  function automatic longint round_q16(input longint x);
    longint r;
    r = (x + HALF_LSB) >>> pssb_pkg::OSC_FRAC;
    if (r > OSC_HI) begin
      r = OSC_HI;
    end else if (r < OSC_LO) begin
      r = OSC_LO;
    end
    return r;
  endfunction

  function automatic dac_item_t modulate_sample(input pssb_pkg::sample_t a,
                                                input pssb_pkg::sample_t q,
                                                input logic last);
    longint    d, qx, mix, nre, nim, mag2, g, t;
    dac_item_t r;
    d = delay_line[tap];
    qx = q;
    delay_line[tap] = a;
    tap = (tap == pssb_pkg::DELAY_DEPTH - 1) ? 0 : tap + 1;
    if (lsb_sel) begin
      mix = d * osc_re + qx * osc_im;
    end else begin
      mix = d * osc_re - qx * osc_im;
    end
    // rotate, then one Newton step toward unit magnitude
    nre = round_q16(osc_re * rot_cos - osc_im * rot_sin);
    nim = round_q16(osc_re * rot_sin + osc_im * rot_cos);
    mag2 = nre * nre + nim * nim;
    g = GAIN_Q16 - ((mag2 + OSC_UNITY) >>> (pssb_pkg::OSC_FRAC + 1));
    osc_re = round_q16(nre * g);
    osc_im = round_q16(nim * g);
    t = mix * DAC_SCALE + (DAC_MID <<< pssb_pkg::MIX_FRAC);
    if (t < 0) begin
      r.code = '0;
    end else begin
      t = t >>> pssb_pkg::MIX_FRAC;
      r.code = (t > DAC_TOP) ? pssb_pkg::DAC_W'(DAC_TOP) : t[pssb_pkg::DAC_W-1:0];
    end
    r.block_end = last;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    dac_item_t want;
    if (!rst_ni) begin
      foreach (delay_line[k]) delay_line[k] = '0;
      tap = 0;
      osc_re = OSC_UNITY;
      osc_im = 0;
      rot_cos = 0;
      rot_sin = OSC_UNITY;
      lsb_sel = 1'b0;
      dac_expect_q.delete();
      fails = 0;
    end else begin
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
        case (cfg.index)
          pssb_pkg::CFG_ROT_COS: rot_cos = pssb_pkg::osc_t'(cfg.data);
          pssb_pkg::CFG_ROT_SIN: rot_sin = pssb_pkg::osc_t'(cfg.data);
          pssb_pkg::CFG_LSB:     lsb_sel = cfg.data[0];
          default: ;
        endcase
      end
      // results first: an item accepted now cannot have its result out yet
      if (dac.valid === 1'b1 && dac.ready === 1'b1) begin
        if (dac_expect_q.size() == 0) begin
          fails++;
          $display("%0t: DAC item with none expected, got code %0d block_end %0b",
                   $time, dac.dac_code, dac.block_end);
        end else begin
          want = dac_expect_q.pop_front();
          if (dac.dac_code !== want.code) begin
            fails++;
            $display("%0t: dac_code expected %0d, got %0d", $time, want.code,
                     dac.dac_code);
          end
          if (dac.block_end !== want.block_end) begin
            fails++;
            $display("%0t: block_end expected %0b, got %0b", $time, want.block_end,
                     dac.block_end);
          end
        end
      end
      if (smp.valid === 1'b1 && smp.ready === 1'b1) begin
        dac_expect_q.push_back(modulate_sample(smp.audio_sample, smp.quadrature_sample,
                                               smp.last_in_block));
      end
    end
    pending_o <= dac_expect_q.size();
    errors_o  <= fails;
  end

endmodule

@@ tb/tb_phasing_ssb_modulator_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_phasing_ssb_modulator_top
// Drives samples and register writes into the SSB modulator, stalls the DAC
// side at random and gives the verdict from the checker's error and pending counts.
// ============================================================================
module tb_phasing_ssb_modulator_top;

  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 20;
  localparam int IDLE_PCT      = 7;
  localparam logic [pssb_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam pssb_pkg::sample_t S_MIN  = pssb_pkg::sample_t'(16'h8000);
  localparam pssb_pkg::sample_t S_MAX  = pssb_pkg::sample_t'(16'h7fff);
  localparam pssb_pkg::osc_t    OSC_P1 = pssb_pkg::osc_t'(65536);
  localparam pssb_pkg::osc_t    OSC_M1 = pssb_pkg::osc_t'(-65536);

  logic clk_i = 1'b0;
  logic rst_ni;
  int   chk_pending;
  int   chk_errors;
  bit   calm;

  pssb_in_if  smp_if ();
  pssb_out_if dac_if ();
  pssb_cfg_if cfg_if ();

  phasing_ssb_modulator_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .smp_i  (smp_if),
    .dac_o  (dac_if),
    .cfg_i  (cfg_if)
  );

  pssb_dac_checker dac_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .smp       (smp_if),
    .dac       (dac_if),
    .cfg       (cfg_if),
    .pending_o (chk_pending),
    .errors_o  (chk_errors)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    dac_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      dac_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((smp_if.valid === 1'b1 && smp_if.ready === 1'b1) ||
          (dac_if.valid === 1'b1 && dac_if.ready === 1'b1) ||
          (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("status: fail");
    $finish;
  end

  function automatic pssb_pkg::sample_t pick_sample();
    case ($urandom_range(0, 7))
      0:       return S_MIN;
      1:       return S_MAX;
      2:       return pssb_pkg::sample_t'(int'($urandom_range(0, 16)) - 8);
      default: return pssb_pkg::sample_t'($urandom);
    endcase
  endfunction

  task automatic unit_rotation(output pssb_pkg::osc_t c, output pssb_pkg::osc_t s);
    int cv, sv;
    cv = int'($urandom_range(0, 131072)) - 65536;
    sv = $rtoi($sqrt(4294967296.0 - real'(cv) * real'(cv)));
    if ($urandom_range(0, 1) == 1) begin
      sv = -sv;
    end
    c = pssb_pkg::osc_t'(cv);
    s = pssb_pkg::osc_t'(sv);
  endtask

  task automatic send_sample(input pssb_pkg::sample_t a, input pssb_pkg::sample_t q,
                             input logic last);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      smp_if.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
    smp_if.valid             <= 1'b1;
    smp_if.audio_sample      <= a;
    smp_if.quadrature_sample <= q;
    smp_if.last_in_block     <= last;
    do @(posedge clk_i); while (smp_if.ready !== 1'b1);
  endtask

  // stop sending and wait until every DAC item has come out
  task automatic drain();
    smp_if.valid <= 1'b0;
    do @(posedge clk_i); while (chk_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_config(input pssb_pkg::osc_t c, input pssb_pkg::osc_t s,
                              input logic lsb);
    logic [pssb_pkg::CFG_IDX_W-1:0]  idx [4];
    logic [pssb_pkg::CFG_DATA_W-1:0] val [4];
    idx = '{CFG_UNUSED, pssb_pkg::CFG_ROT_COS, pssb_pkg::CFG_ROT_SIN, pssb_pkg::CFG_LSB};
    val = '{pssb_pkg::CFG_DATA_W'($urandom), c, s,
            {(pssb_pkg::CFG_DATA_W-1)'($urandom), lsb}};
    for (int k = 0; k < 4; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[k];
      cfg_if.data  <= val[k];
      do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(input pssb_pkg::osc_t c, input pssb_pkg::osc_t s,
                           input logic lsb, input int n,
                           input bit no_idle, input int pause_at);
    drain();
    apply_config(c, s, lsb);
    calm = no_idle;
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) begin
        drain();
      end
      send_sample(pick_sample(), pick_sample(), $urandom_range(0, 7) == 0);
    end
    calm = 1'b0;
  endtask

  initial begin : stimulus
    pssb_pkg::sample_t corner_vals [4];
    pssb_pkg::osc_t    c, s;
    corner_vals = '{S_MIN, S_MAX, pssb_pkg::sample_t'(0), pssb_pkg::sample_t'(-1)};
    calm = 1'b0;
    rst_ni                   <= 1'b0;
    smp_if.valid             <= 1'b0;
    smp_if.audio_sample      <= '0;
    smp_if.quadrature_sample <= '0;
    smp_if.last_in_block     <= 1'b0;
    cfg_if.valid             <= 1'b0;
    cfg_if.index             <= '0;
    cfg_if.data              <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setting: quarter-turn steps, so odd items see the quadrature path
    for (int i = 0; i < 20; i++) begin
      send_sample(corner_vals[i % 4], corner_vals[(i / 2) % 4], logic'(i[0] ^ i[2]));
    end

    run_phase(OSC_P1, pssb_pkg::osc_t'(0), 1'b1, 60, 1'b0, -1);
    unit_rotation(c, s);
    run_phase(c, s, 1'b0, 70, 1'b0, 35);
    unit_rotation(c, s);
    run_phase(c, s, 1'b1, 80, 1'b1, -1);
    run_phase(OSC_M1, OSC_P1, 1'b0, 60, 1'b0, -1);
    unit_rotation(c, s);
    run_phase(c, s, logic'($urandom_range(0, 1)), 60, 1'b0, -1);
    // step registers outside the unit circle, oscillator saturates
    run_phase(pssb_pkg::osc_t'($urandom), pssb_pkg::osc_t'($urandom),
              logic'($urandom_range(0, 1)), 40, 1'b0, -1);
    run_phase(pssb_pkg::OSC_MAX, pssb_pkg::OSC_MIN, 1'b1, 30, 1'b0, -1);
    drain();

    if (chk_errors == 0 && chk_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
